// ===== rtl/core/i2crm_pkg.sv =====
package i2crm_pkg;

  // largest transfer count per transaction
  localparam int unsigned MaxBytes = 8;
  localparam logic [3:0] MAX_COUNT = 4'(MaxBytes);

  // item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_BEGIN = 1'b1;

  // completion status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ADDR_NACK  = 3'd1;
  localparam logic [2:0] ST_REG_NACK   = 3'd2;
  localparam logic [2:0] ST_RADDR_NACK = 3'd3;
  localparam logic [2:0] ST_DATA_NACK  = 3'd4;
  localparam logic [2:0] ST_BUSY       = 3'd5;

  // R/W bit appended to the device address
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        is_read;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [3:0]  byte_count;
    logic [63:0] write_bytes;
    logic        sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } out_item_t;

endpackage

// ===== rtl/core/i2crm_ifs.sv =====
// request channel: begin and tick items
interface i2crm_in_if;
  logic                 valid;
  logic                 ready;
  i2crm_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// response channel: one result per item
interface i2crm_out_if;
  logic                 valid;
  logic                 ready;
  i2crm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/i2c_register_master.sv =====
// A transfer on req has its result in the rsp register in the next cycle.
// Throughput: one item per cycle; the bus sequencer state updates in a single
// pass per accepted item. req stalls only while a result sits in the rsp
// register and rsp is not ready.
// Reset (rst, synchronous): sequencer idle, both lines released, rsp empty,
// ticks_per_phase back to 1.
module i2c_register_master (
  input  logic             clk,
  input  logic             rst,
  i2crm_in_if.sink         req,
  i2crm_out_if.source      rsp,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);

  logic                 accept;
  logic [7:0]           ticks_per_phase;
  logic                 rsp_valid;
  i2crm_pkg::out_item_t rsp_data;
  i2crm_pkg::out_item_t result;

  // take a new item whenever the result register is free or draining
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // timing register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= 8'd1;
    end else if (cfg_we) begin
      ticks_per_phase <= cfg_wdata;
    end
  end

  i2crm_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .step            (accept),
    .item            (req.data),
    .ticks_per_phase (ticks_per_phase),
    .result          (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // a nonzero status only comes with a completion
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != i2crm_pkg::ST_OK) |-> rsp_data.done_res)
    else $error("status set without done");

  // a received byte is only reported while a read is running
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.read_valid |-> rsp_data.busy_res && !rsp_data.done_res)
    else $error("read byte outside a transaction");

  // a rejected begin leaves the running transaction in place
  a_busy_reject: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == i2crm_pkg::ST_BUSY) |-> rsp_data.busy_res)
    else $error("busy reject dropped the transaction");

  // an accepted item always lands in the result register
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted item lost");

endmodule

// ===== rtl/core/i2crm_seq.sv =====
module i2crm_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  i2crm_pkg::in_item_t  item,
  input  logic [7:0]           ticks_per_phase,
  output i2crm_pkg::out_item_t result
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_AW, PH_AW_ACK, PH_REG, PH_REG_ACK, PH_WD, PH_WD_ACK,
    PH_RESTART, PH_AR, PH_AR_ACK, PH_RD, PH_RD_ACK, PH_STOP
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  quarter, quarter_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [3:0]  bytes_done, bytes_done_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [1:0]  line_drive, line_drive_next;
  logic [2:0]  pend_status, pend_status_next;

  // latched request (payload, no reset needed)
  logic        hdr_read;
  logic [6:0]  hdr_addr;
  logic [7:0]  hdr_reg;
  logic [3:0]  hdr_count;
  logic [63:0] wr_data;
  logic        latch;

  logic [3:0]  count;
  logic [7:0]  limit;
  logic [8:0]  tick_sum;
  logic        redrive;
  logic        keep;
  logic        val;
  logic        sda;
  logic        nack;
  logic [7:0]  rbyte;
  logic        rvalid;
  logic        done;
  logic [2:0]  st;

  assign count = (hdr_count > i2crm_pkg::MAX_COUNT) ? i2crm_pkg::MAX_COUNT : hdr_count;
  assign limit = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
  assign tick_sum = {1'b0, tick_count} + 9'd1;
  assign nack = shift_byte[0];
  assign keep = line_drive[0];

  // next-state and result for one item
  always_comb begin
    phase_next       = phase;
    quarter_next     = quarter;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    bytes_done_next  = bytes_done;
    shift_byte_next  = shift_byte;
    pend_status_next = pend_status;
    latch   = 1'b0;
    redrive = 1'b0;
    rbyte   = 8'd0;
    rvalid  = 1'b0;
    done    = 1'b0;
    st      = i2crm_pkg::ST_OK;
    if (step) begin
      if (item.kind == i2crm_pkg::KIND_BEGIN) begin
        if (phase != PH_IDLE) begin
          done = 1'b1;
          st   = i2crm_pkg::ST_BUSY;
        end else begin
          latch            = 1'b1;
          phase_next       = PH_START;
          quarter_next     = 2'd0;
          tick_count_next  = 8'd0;
          bit_index_next   = 3'd0;
          bytes_done_next  = 4'd0;
          shift_byte_next  = 8'd0;
          pend_status_next = i2crm_pkg::ST_OK;
          redrive          = 1'b1;
        end
      end else if (phase != PH_IDLE) begin
        if (tick_sum >= {1'b0, limit}) begin
          tick_count_next = 8'd0;
          redrive         = 1'b1;
          // sample SDA at the end of the first high quarter
          if (quarter == 2'd2) begin
            if (phase == PH_AW_ACK || phase == PH_REG_ACK ||
                phase == PH_WD_ACK || phase == PH_AR_ACK) begin
              shift_byte_next = {7'd0, item.sda_sample};
            end else if (phase == PH_RD) begin
              shift_byte_next = {shift_byte[6:0], item.sda_sample};
              if (bit_index == 3'd7) begin
                rbyte           = shift_byte_next;
                rvalid          = 1'b1;
                bytes_done_next = bytes_done + 4'd1;
              end
            end
          end
          if (quarter != 2'd3) begin
            quarter_next = quarter + 2'd1;
          end else begin
            // end of a bus step
            quarter_next = 2'd0;
            case (phase)
              PH_START: begin
                phase_next = PH_AW;
                shift_byte_next = {hdr_addr, i2crm_pkg::RW_WRITE};
                bit_index_next = 3'd0;
              end
              PH_AW, PH_REG, PH_WD, PH_AR: begin
                shift_byte_next = {shift_byte[6:0], 1'b0};
                if (bit_index == 3'd7) begin
                  shift_byte_next = 8'd0;
                  case (phase)
                    PH_AW:   phase_next = PH_AW_ACK;
                    PH_REG:  phase_next = PH_REG_ACK;
                    PH_WD:   phase_next = PH_WD_ACK;
                    default: phase_next = PH_AR_ACK;
                  endcase
                end else begin
                  bit_index_next = bit_index + 3'd1;
                end
              end
              PH_AW_ACK: begin
                if (nack) begin
                  phase_next = PH_STOP;
                  pend_status_next = i2crm_pkg::ST_ADDR_NACK;
                end else begin
                  phase_next = PH_REG;
                  shift_byte_next = hdr_reg;
                  bit_index_next = 3'd0;
                end
              end
              PH_REG_ACK: begin
                if (nack) begin
                  phase_next = PH_STOP;
                  pend_status_next = i2crm_pkg::ST_REG_NACK;
                end else if (hdr_read) begin
                  phase_next = PH_RESTART;
                end else if (count != 4'd0) begin
                  bytes_done_next = 4'd0;
                  phase_next = PH_WD;
                  shift_byte_next = wr_data[7:0];
                  bit_index_next = 3'd0;
                end else begin
                  phase_next = PH_STOP;
                  pend_status_next = i2crm_pkg::ST_OK;
                end
              end
              PH_WD_ACK: begin
                if (nack) begin
                  phase_next = PH_STOP;
                  pend_status_next = i2crm_pkg::ST_DATA_NACK;
                end else begin
                  bytes_done_next = bytes_done + 4'd1;
                  if (bytes_done_next < count) begin
                    phase_next = PH_WD;
                    shift_byte_next = wr_data[{bytes_done_next[2:0], 3'b000} +: 8];
                    bit_index_next = 3'd0;
                  end else begin
                    phase_next = PH_STOP;
                    pend_status_next = i2crm_pkg::ST_OK;
                  end
                end
              end
              PH_RESTART: begin
                phase_next = PH_AR;
                shift_byte_next = {hdr_addr, i2crm_pkg::RW_READ};
                bit_index_next = 3'd0;
              end
              PH_AR_ACK: begin
                if (nack) begin
                  phase_next = PH_STOP;
                  pend_status_next = i2crm_pkg::ST_RADDR_NACK;
                end else if (count != 4'd0) begin
                  bytes_done_next = 4'd0;
                  phase_next = PH_RD;
                  shift_byte_next = 8'd0;
                  bit_index_next = 3'd0;
                end else begin
                  phase_next = PH_STOP;
                  pend_status_next = i2crm_pkg::ST_OK;
                end
              end
              PH_RD: begin
                if (bit_index == 3'd7) begin
                  phase_next = PH_RD_ACK;
                end else begin
                  bit_index_next = bit_index + 3'd1;
                end
              end
              PH_RD_ACK: begin
                if (bytes_done < count) begin
                  phase_next = PH_RD;
                  shift_byte_next = 8'd0;
                  bit_index_next = 3'd0;
                end else begin
                  phase_next = PH_STOP;
                  pend_status_next = i2crm_pkg::ST_OK;
                end
              end
              default: begin
                // stop finished: report and go idle
                phase_next = PH_IDLE;
                done = 1'b1;
                st = pend_status;
                pend_status_next = i2crm_pkg::ST_OK;
              end
            endcase
          end
        end else begin
          tick_count_next = tick_sum[7:0];
        end
      end
    end
  end

  // line levels for the new phase and quarter
  always_comb begin
    val = 1'b1;
    sda = 1'b1;
    line_drive_next = line_drive;
    if (redrive) begin
      case (phase_next)
        PH_IDLE:    sda = 1'b1;
        PH_START:   sda = (quarter_next < 2'd2);
        PH_RESTART: sda = (quarter_next == 2'd0) ? keep : (quarter_next != 2'd3);
        PH_STOP:    sda = (quarter_next == 2'd0) ? keep : (quarter_next == 2'd3);
        default: begin
          if (phase_next == PH_AW || phase_next == PH_REG ||
              phase_next == PH_WD || phase_next == PH_AR) begin
            val = shift_byte_next[7];
          end else if (phase_next == PH_RD_ACK) begin
            val = !(bytes_done_next < count);
          end
          sda = (quarter_next == 2'd0) ? keep : val;
        end
      endcase
      if (phase_next == PH_IDLE || phase_next == PH_START) begin
        line_drive_next = {1'b1, sda};
      end else begin
        line_drive_next = {quarter_next[1], sda};
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      quarter     <= 2'd0;
      tick_count  <= 8'd0;
      bit_index   <= 3'd0;
      bytes_done  <= 4'd0;
      shift_byte  <= 8'd0;
      line_drive  <= 2'b11;
      pend_status <= i2crm_pkg::ST_OK;
    end else begin
      phase       <= phase_next;
      quarter     <= quarter_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      bytes_done  <= bytes_done_next;
      shift_byte  <= shift_byte_next;
      line_drive  <= line_drive_next;
      pend_status <= pend_status_next;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (latch) begin
      hdr_read  <= item.is_read;
      hdr_addr  <= item.device_address;
      hdr_reg   <= item.register_address;
      hdr_count <= item.byte_count;
      wr_data   <= item.write_bytes;
    end
  end

  assign result.scl_release = line_drive_next[1];
  assign result.sda_release = line_drive_next[0];
  assign result.read_byte   = rbyte;
  assign result.read_valid  = rvalid;
  assign result.busy_res    = (phase_next != PH_IDLE);
  assign result.done_res    = done;
  assign result.status      = st;

endmodule

// ===== tb/sv/i2c_register_master_test.sv =====
`timescale 1ns / 1ps

module i2c_register_master_test;
  import i2crm_pkg::*;

  // bus sequencer steps, mirrored from the block's behavior
  typedef enum logic [4:0] {
    STEP_IDLE, STEP_START, STEP_AW, STEP_AW_ACK, STEP_REG, STEP_REG_ACK,
    STEP_WD, STEP_WD_ACK, STEP_RESTART, STEP_AR, STEP_AR_ACK, STEP_RD,
    STEP_RD_ACK, STEP_STOP
  } bus_step_e;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } plan_row_t;

  localparam out_item_t LINES_IDLE = '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK};

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  i2crm_in_if  req_ch ();
  i2crm_out_if rsp_ch ();

  i2c_register_master dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor copy of the sequencer and its setting
  logic [7:0]  tpp_q        = 8'd1;
  bus_step_e   step_q       = STEP_IDLE;
  logic [1:0]  quarter_q    = '0;
  logic [7:0]  tick_q       = '0;
  logic [2:0]  bit_q        = '0;
  logic [3:0]  done_bytes_q = '0;
  logic [7:0]  shift_q      = '0;
  logic [63:0] wdata_q      = '0;
  logic        rd_q         = 1'b0;
  logic [6:0]  dev_q        = '0;
  logic [7:0]  regaddr_q    = '0;
  logic [3:0]  count_q      = '0;
  logic        scl_q        = 1'b1;
  logic        sda_q        = 1'b1;
  logic [2:0]  pend_q       = ST_OK;

  out_item_t bus_outcomes[$];
  int        mismatches    = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        long_hold_req = 1'b0;

  function automatic bit is_ack_step(bus_step_e s);
    return s inside {STEP_AW_ACK, STEP_REG_ACK, STEP_WD_ACK, STEP_AR_ACK};
  endfunction

  function automatic void load_byte(bus_step_e s, logic [7:0] b);
    step_q  = s;
    shift_q = b;
    bit_q   = '0;
  endfunction

  function automatic void go_stop(logic [2:0] st);
    step_q = STEP_STOP;
    pend_q = st;
  endfunction

  // line levels for the current step and quarter
  function automatic void refresh_lines();
    logic val;
    val = 1'b1;
    case (step_q)
      STEP_IDLE: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
      end
      STEP_START: begin
        scl_q = 1'b1;
        sda_q = (quarter_q < 2);
      end
      STEP_RESTART: begin
        scl_q = (quarter_q >= 2);
        if (quarter_q != 0) sda_q = (quarter_q != 3);
      end
      STEP_STOP: begin
        scl_q = (quarter_q >= 2);
        if (quarter_q != 0) sda_q = (quarter_q == 3);
      end
      default: begin
        if (step_q inside {STEP_AW, STEP_REG, STEP_WD, STEP_AR}) val = shift_q[7];
        else if (step_q == STEP_RD_ACK) val = !(done_bytes_q < count_q);
        scl_q = (quarter_q >= 2);
        // SDA holds its level through quarter 0
        if (quarter_q != 0) sda_q = val;
      end
    endcase
  endfunction

  // end of a bus step; returns 1 when the transaction is over
  function automatic bit close_step();
    bit nack;
    nack = shift_q[0];
    case (step_q)
      STEP_START: load_byte(STEP_AW, {dev_q, RW_WRITE});
      STEP_AW, STEP_REG, STEP_WD, STEP_AR: begin
        shift_q = shift_q << 1;
        if (bit_q == 3'd7) begin
          step_q  = bus_step_e'(step_q + 1);
          shift_q = '0;
        end else begin
          bit_q++;
        end
      end
      STEP_AW_ACK: begin
        if (nack) go_stop(ST_ADDR_NACK);
        else load_byte(STEP_REG, regaddr_q);
      end
      STEP_REG_ACK: begin
        if (nack) go_stop(ST_REG_NACK);
        else if (rd_q) step_q = STEP_RESTART;
        else if (count_q != 0) begin
          done_bytes_q = '0;
          load_byte(STEP_WD, wdata_q[7:0]);
        end else go_stop(ST_OK);
      end
      STEP_WD_ACK: begin
        if (nack) go_stop(ST_DATA_NACK);
        else begin
          done_bytes_q++;
          if (done_bytes_q < count_q) load_byte(STEP_WD, wdata_q[done_bytes_q[2:0] * 8 +: 8]);
          else go_stop(ST_OK);
        end
      end
      STEP_RESTART: load_byte(STEP_AR, {dev_q, RW_READ});
      STEP_AR_ACK: begin
        if (nack) go_stop(ST_RADDR_NACK);
        else if (count_q != 0) begin
          done_bytes_q = '0;
          load_byte(STEP_RD, 8'h00);
        end else go_stop(ST_OK);
      end
      STEP_RD: begin
        if (bit_q == 3'd7) step_q = STEP_RD_ACK;
        else bit_q++;
      end
      STEP_RD_ACK: begin
        if (done_bytes_q < count_q) load_byte(STEP_RD, 8'h00);
        else go_stop(ST_OK);
      end
      default: begin
        step_q = STEP_IDLE;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // expected bus result for one accepted item
  function automatic out_item_t advance_bus(in_item_t it);
    out_item_t  r;
    logic [7:0] limit;
    r = '0;
    if (it.kind == KIND_BEGIN) begin
      if (step_q != STEP_IDLE) begin
        r.done_res = 1'b1;
        r.status   = ST_BUSY;
      end else begin
        rd_q         = it.is_read;
        dev_q        = it.device_address;
        regaddr_q    = it.register_address;
        count_q      = (it.byte_count > MAX_COUNT) ? MAX_COUNT : it.byte_count;
        wdata_q      = it.write_bytes;
        step_q       = STEP_START;
        quarter_q    = '0;
        tick_q       = '0;
        bit_q        = '0;
        done_bytes_q = '0;
        shift_q      = '0;
        pend_q       = ST_OK;
        refresh_lines();
      end
    end else if (step_q != STEP_IDLE) begin
      limit = (tpp_q == 0) ? 8'd1 : tpp_q;
      tick_q++;
      if (tick_q >= limit) begin
        tick_q = '0;
        // SDA is taken at the end of quarter 2, SCL high for a full quarter
        if (quarter_q == 2) begin
          if (is_ack_step(step_q)) begin
            shift_q = {7'd0, it.sda_sample};
          end else if (step_q == STEP_RD) begin
            shift_q = {shift_q[6:0], it.sda_sample};
            if (bit_q == 3'd7) begin
              r.read_byte  = shift_q;
              r.read_valid = 1'b1;
              done_bytes_q++;
            end
          end
        end
        if (quarter_q != 3) begin
          quarter_q++;
        end else begin
          quarter_q = '0;
          if (close_step()) begin
            r.done_res = 1'b1;
            r.status   = pend_q;
            pend_q     = ST_OK;
          end
        end
        refresh_lines();
      end
    end
    r.scl_release = scl_q;
    r.sda_release = sda_q;
    r.busy_res    = (step_q != STEP_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // present one item until transferred, then log its expected result
  task automatic offer(input in_item_t it, input bit fixed, input out_item_t want);
    out_item_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = advance_bus(it);
    bus_outcomes.push_back(fixed ? want : predicted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // result side: check each transfer, random stalls, one long hold-off
  initial begin
    int        hold_left;
    out_item_t want;
    out_item_t got;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (bus_outcomes.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = bus_outcomes.pop_front();
          check_field("scl_release", got.scl_release, want.scl_release);
          check_field("sda_release", got.sda_release, want.sda_release);
          check_field("read_byte", got.read_byte, want.read_byte);
          check_field("read_valid", got.read_valid, want.read_valid);
          check_field("busy_res", got.busy_res, want.busy_res);
          check_field("done_res", got.done_res, want.done_res);
          check_field("status", got.status, want.status);
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // stimulus
  initial begin
    plan_row_t plan[$];
    in_item_t  it;
    int        tpp_plan[6];
    int        items_plan[6];
    int        counted;
    int        sel;

    tpp_plan   = '{2, 1, 0, 255, 3, 1};
    items_plan = '{320, 320, 300, 150, 300, 300};

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= 8'h00;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;

    // directed: idle ticks, extreme begin, busy reject, then bus ticks
    plan.push_back('{in_item_t'{KIND_TICK, 1'b0, 7'h00, 8'h00, 4'h0, 64'h0, 1'b1},
                     1'b1, LINES_IDLE});
    plan.push_back('{in_item_t'{KIND_TICK, 1'b1, 7'h7f, 8'hff, 4'hf, '1, 1'b0},
                     1'b1, LINES_IDLE});
    plan.push_back('{in_item_t'{KIND_BEGIN, 1'b0, 7'h7f, 8'hff, 4'hf, '1, 1'b0},
                     1'b1, out_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, ST_OK}});
    plan.push_back('{in_item_t'{KIND_BEGIN, 1'b1, 7'h00, 8'h00, 4'h0, 64'h0, 1'b1},
                     1'b1, out_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, ST_BUSY}});
    for (int i = 0; i < 20; i++)
      plan.push_back('{in_item_t'{KIND_TICK, i[0], {7{i[1]}}, {8{i[0]}}, 4'h0, 64'h0, i[0]},
                       1'b0, out_item_t'('0)});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 21;
    recv_idle_pct = 69;
    foreach (plan[i]) offer(plan[i].item, plan[i].fixed, plan[i].want);

    for (int p = 0; p < 6; p++) begin
      // retune only with nothing in flight
      req_ch.valid <= 1'b0;
      while (bus_outcomes.size() != 0) @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= 8'(tpp_plan[p]);
      @(posedge clk);
      tpp_q = 8'(tpp_plan[p]);
      cfg_we <= 1'b0;

      case (p / 2)
        0: begin send_idle_pct = 21; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p == 4) long_hold_req = 1'b1;

      counted = 0;
      while (counted < items_plan[p]) begin
        it.is_read          = 1'($urandom_range(0, 1));
        it.device_address   = 7'($urandom_range(0, 127));
        it.register_address = 8'($urandom_range(0, 255));
        it.write_bytes      = {$urandom(), $urandom()};
        sel = $urandom_range(0, 3);
        if (sel == 0) it.byte_count = 4'd0;
        else if (sel == 3) it.byte_count = 4'($urandom_range(0, 15));
        else it.byte_count = 4'($urandom_range(1, 3));
        // idle: start a transaction soon; busy: an occasional rejected begin
        if (step_q == STEP_IDLE) it.kind = ($urandom_range(0, 99) < 60) ? KIND_BEGIN : KIND_TICK;
        else it.kind = ($urandom_range(0, 99) < 2) ? KIND_BEGIN : KIND_TICK;
        // target acks most bytes; data and other bits are random
        if (is_ack_step(step_q)) it.sda_sample = ($urandom_range(0, 99) < 10);
        else it.sda_sample = 1'($urandom_range(0, 1));
        if (!(it.kind == KIND_TICK && step_q == STEP_IDLE)) counted++;
        offer(it, 1'b0, out_item_t'('0));
      end
    end

    req_ch.valid <= 1'b0;
    while (bus_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/i2crm_pkg.sv
rtl/core/i2crm_ifs.sv
rtl/core/i2crm_seq.sv
rtl/core/i2c_register_master.sv
tb/sv/i2c_register_master_test.sv
